/* design/ggc_pkg.sv */
package ggc_pkg;

    // Largest graph the block can hold.
    localparam int MAX_VERTICES = 64;

    // Field widths of the item and result formats.
    localparam int VW  = 6;
    localparam int VCW = 7;

    // Address width of the per-vertex stores.
    localparam int AW = $clog2(MAX_VERTICES);

    // Vertex count after reset.
    localparam logic [VCW-1:0] VCOUNT_RESET = 7'd64;

    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    // Operation codes of an input item.
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef struct packed {
        logic          op;
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
    } t_in_item;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [VW-1:0] color;
        logic          last;
    } t_result;

    // Classified command. An edge is stored once, in the row of its higher
    // endpoint at the column of its lower endpoint.
    typedef struct packed {
        logic          is_run;
        logic [AW-1:0] row;
        logic [AW-1:0] col;
    } t_cmd;

endpackage

/* design/ggc_ram.sv */
module ggc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ggc_front.sv */
module ggc_front
    import ggc_pkg::*;
(
    input  logic     i_push,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);

    logic accept;
    logic is_run;
    logic a_ok;
    logic b_ok;
    logic a_high;

    assign accept = i_push && !i_q_full;
    assign is_run = (i_item.op == OP_RUN);
    assign a_ok   = {1'b0, i_item.vertex_a} < VCW'(MAX_VERTICES);
    assign b_ok   = {1'b0, i_item.vertex_b} < VCW'(MAX_VERTICES);
    assign a_high = i_item.vertex_a > i_item.vertex_b;

    // Self loops are taken and dropped here; a 6-bit endpoint always lies inside the graph.
    assign o_q_push = accept &&
                      (is_run || (a_ok && b_ok && (i_item.vertex_a != i_item.vertex_b)));

    always_comb begin
        o_q_cmd.is_run = is_run;
        if (a_high) begin
            o_q_cmd.row = AW'(i_item.vertex_a);
            o_q_cmd.col = AW'(i_item.vertex_b);
        end else begin
            o_q_cmd.row = AW'(i_item.vertex_b);
            o_q_cmd.col = AW'(i_item.vertex_a);
        end
    end

    assign o_full = i_q_full;

endmodule

/* design/ggc_cmd_fifo.sv */
module ggc_cmd_fifo
    import ggc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wptr;
    logic [CMD_AW-1:0] r_rptr;
    logic [CMD_AW:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == (CMD_AW+1)'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

/* design/ggc_back.sv */
module ggc_back
    import ggc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [VCW-1:0] i_cfg_wdata,
    input  logic           i_q_empty,
    input  t_cmd           i_q_cmd,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output t_result        o_result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROW   = 3'd1;
    localparam logic [2:0] ST_ROWW  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_PICK  = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [VCW-1:0]          r_count;
    logic [VCW-1:0]          r_n, n_n;
    logic [AW-1:0]           r_u, n_u;
    logic [AW-1:0]           r_v, n_v;
    logic [MAX_VERTICES-1:0] r_row, n_row;
    logic [MAX_VERTICES-1:0] r_used, n_used;
    logic                    r_pend_vld, n_pend_vld;
    logic [AW-1:0]           r_pend_v;
    logic                    r_e2_vld;
    logic [AW-1:0]           r_e2_row;
    logic [AW-1:0]           r_e2_col;
    logic                    r_lw_vld;
    logic [AW-1:0]           r_lw_row;
    logic [MAX_VERTICES-1:0] r_lw_data;
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic                    r_out_vld, n_out_vld;
    t_result                 r_out, n_out;

    logic [MAX_VERTICES-1:0] adj_rdata;
    logic [MAX_VERTICES-1:0] e2_old;
    logic [MAX_VERTICES-1:0] e2_new;
    logic [AW-1:0]           adj_raddr;
    logic [VW-1:0]           clr_rdata;
    logic                    clr_we;
    logic [AW-1:0]           clr_raddr;
    logic [MAX_VERTICES-1:0] free_1h;
    logic [AW-1:0]           pick;
    logic [VCW-1:0]          sat_n;
    logic                    edge_go;
    logic                    run_go;
    logic                    slot_free;
    logic                    is_last;

    assign edge_go   = (r_state == ST_IDLE) && !i_q_empty && !i_q_cmd.is_run;
    assign run_go    = (r_state == ST_IDLE) && !i_q_empty && i_q_cmd.is_run && !r_e2_vld;
    assign o_q_pop   = edge_go || run_go;
    assign slot_free = !r_out_vld || i_pop;
    assign sat_n     = (r_count > VCW'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : r_count;
    assign is_last   = (VCW'(r_u) + VCW'(1)) == r_n;

    // Read-modify-write of an adjacency row; the write of the previous cycle
    // is forwarded since the memory returned the row from before it.
    always_comb begin
        if (r_lw_vld && (r_lw_row == r_e2_row)) begin
            e2_old = r_lw_data;
        end else if (r_row_vld[r_e2_row]) begin
            e2_old = adj_rdata;
        end else begin
            e2_old = '0;
        end
        e2_new           = e2_old;
        e2_new[r_e2_col] = 1'b1;
    end

    assign adj_raddr = (r_state == ST_IDLE) ? i_q_cmd.row : r_u;
    assign clr_raddr = r_v;
    assign clr_we    = (r_state == ST_PICK) && slot_free;

    ggc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (r_e2_vld),
        .i_waddr (r_e2_row),
        .i_wdata (e2_new),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    ggc_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (clr_we),
        .i_waddr (r_u),
        .i_wdata (VW'(pick)),
        .i_raddr (clr_raddr),
        .o_rdata (clr_rdata)
    );

    // Lowest color not in use: isolate the lowest zero bit, then encode it.
    assign free_1h = ~r_used & (r_used + 1'b1);

    always_comb begin
        pick = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (free_1h[i]) begin
                pick = pick | AW'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_u        = r_u;
        n_v        = r_v;
        n_row      = r_row;
        n_used     = r_used;
        n_pend_vld = 1'b0;
        n_out_vld  = r_out_vld && !i_pop;
        n_out      = r_out;

        // Fold in the color of the neighbor read in the previous cycle.
        if (r_pend_vld && r_row[r_pend_v]) begin
            n_used[AW'(clr_rdata)] = 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (run_go && (sat_n != '0)) begin
                    n_n     = sat_n;
                    n_u     = '0;
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                n_state = ST_ROWW;
            end
            ST_ROWW: begin
                n_row   = r_row_vld[r_u] ? adj_rdata : '0;
                n_used  = '0;
                n_v     = '0;
                n_state = (r_u == '0) ? ST_PICK : ST_SCAN;
            end
            ST_SCAN: begin
                n_pend_vld = 1'b1;
                n_v        = r_v + 1'b1;
                if (r_v == (r_u - 1'b1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                if (slot_free) begin
                    n_out_vld    = 1'b1;
                    n_out.vertex = VW'(r_u);
                    n_out.color  = VW'(pick);
                    n_out.last   = is_last;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_u     = r_u + 1'b1;
                        n_state = ST_ROW;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= VCOUNT_RESET;
            r_pend_vld <= 1'b0;
            r_e2_vld   <= 1'b0;
            r_lw_vld   <= 1'b0;
            r_row_vld  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_e2_vld   <= edge_go;
            r_lw_vld   <= r_e2_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (r_e2_vld) begin
                r_row_vld[r_e2_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_u       <= n_u;
        r_v       <= n_v;
        r_row     <= n_row;
        r_used    <= n_used;
        r_pend_v  <= r_v;
        r_e2_row  <= i_q_cmd.row;
        r_e2_col  <= i_q_cmd.col;
        r_lw_row  <= r_e2_row;
        r_lw_data <= e2_new;
        r_out     <= n_out;
    end

    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

endmodule

/* design/greedy_graph_coloring_unit.sv */
// Edge items: one item per cycle while the command queue is not full; an edge passes
// through the command queue and the e2 register before it reaches the adjacency store.
// Run item: each vertex u passes through ROW, ROWW, SCAN (one color store read per lower
// vertex, on its single read port), DRAIN and PICK; vertex 0 skips SCAN and DRAIN.
// Synchronous active-low reset clears the graph (per-row valid flags), the queues and
// the vertex count (back to 64); no clearing pass is needed.
module greedy_graph_coloring_unit
    import ggc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  t_in_item       i_item,
    output logic           empty,
    input  logic           pop,
    output t_result        o_result,
    input  logic           i_cfg_we,
    input  logic [VCW-1:0] i_cfg_wdata
);

    // The front classifies each item as it is taken: runs and real edges go
    // into the command queue, while self loops are dropped on the spot. An
    // edge is normalized so that it lives only in the row of its higher
    // endpoint, since coloring only ever asks about lower neighbors.
    logic q_push;
    t_cmd q_in;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_out;

    ggc_front u_front (
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in)
    );

    // The command queue lets the front keep taking items while the back is
    // busy with a run.
    ggc_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out)
    );

    // The back writes edges into the adjacency memory at one per cycle while
    // no run is in progress, and performs the first-fit coloring. For each
    // vertex it reads its row of lower neighbors, scans the color store once
    // per lower vertex to build the set of colors in use, then picks the
    // lowest free color. Each result item waits in an output register, so the
    // back stalls at PICK only while that register is occupied and not popped.
    ggc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_out),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

/* design/ggc_checker.sv */
module ggc_checker
    import ggc_pkg::*;
(
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           empty,
    input logic           pop,
    input t_result        o_result,
    input logic           i_cfg_we,
    input logic [VCW-1:0] i_cfg_wdata
);

    logic [VW-1:0]  r_exp_vertex;
    logic [VCW-1:0] r_cnt;
    logic [VCW-1:0] sat_cnt;

    assign sat_cnt = (r_cnt > VCW'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_vertex <= '0;
            r_cnt        <= VCOUNT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cnt <= i_cfg_wdata;
            end
            if (pop && !empty) begin
                r_exp_vertex <= o_result.last ? '0 : o_result.vertex + 1'b1;
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("result changed while waiting");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.vertex == r_exp_vertex)
        else $error("vertex out of order");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.last |-> ({1'b0, o_result.vertex} + 7'd1) == sat_cnt)
        else $error("last flag on wrong vertex");

    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.color <= o_result.vertex)
        else $error("color exceeds vertex index");

endmodule

bind greedy_graph_coloring_unit ggc_checker u_ggc_checker (.*);
